### sv/calendar_span_business_days_macros.svh
// Assertion helpers; the using module must have clk and rst in scope.
`ifndef CALENDAR_SPAN_BUSINESS_DAYS_MACROS_SVH
`define CALENDAR_SPAN_BUSINESS_DAYS_MACROS_SVH

// Same-cycle implication.
`define CSBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/csbd_pkg.sv
package csbd_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int CNT_W  = 22;
  localparam int WD_W   = 3;
  localparam int R400_W = 9;
  localparam int MUL_A_W = 14;
  localparam int MUL_K_W = 16;
  localparam int PROD_W  = 30;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MON_W-1:0]  MON_MIN  = 4'd1;
  localparam logic [MON_W-1:0]  MON_MAX  = 4'd12;
  localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
  localparam logic [DAY_W-1:0]  DAY_MIN  = 5'd1;

  // floor(v / 100) = (v * RECIP_100) >> RECIP_100_SH for v < 16384
  localparam logic [MUL_K_W-1:0] RECIP_100    = 16'd5243;
  localparam int                 RECIP_100_SH = 19;
  // underestimates floor(v / 7) by at most one for v < 16384
  localparam logic [MUL_K_W-1:0] RECIP_7      = 16'd37449;
  localparam int                 RECIP_7_SH   = 18;

  localparam logic [WD_W-1:0] WD_SUNDAY   = 3'd0;
  localparam logic [WD_W-1:0] WD_SATURDAY = 3'd6;

  typedef struct packed {
    logic load;
    logic sel;
    logic q400;
    logic q100;
    logic q4;
    logic sum;
    logic q7;
    logic wd;
    logic init;
    logic walk;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic less;
    logic out_busy;
  } stat_t;

  function automatic logic is_leap400(input logic [R400_W-1:0] r);
    return ((r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300))
           || (r == 9'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 with March as mm = 1
  function automatic logic [DAY_W-1:0] month_term(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] t;
    unique case (m)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

### sv/csbd_if.sv
interface csbd_req_if;
  logic                          valid;
  logic                          ready;
  logic [csbd_pkg::YEAR_W-1:0]   start_year;
  logic [csbd_pkg::MON_W-1:0]    start_month;
  logic [csbd_pkg::DAY_W-1:0]    start_day;
  logic [csbd_pkg::YEAR_W-1:0]   end_year;
  logic [csbd_pkg::MON_W-1:0]    end_month;
  logic [csbd_pkg::DAY_W-1:0]    end_day;
  logic                          include_last;

  modport source (output valid, start_year, start_month, start_day, end_year,
                  end_month, end_day, include_last, input ready);
  modport sink (input valid, start_year, start_month, start_day, end_year,
                end_month, end_day, include_last, output ready);
endinterface

interface csbd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [csbd_pkg::CNT_W-1:0]  total_days;
  logic [csbd_pkg::CNT_W-1:0]  business_days;
  logic [csbd_pkg::WD_W-1:0]   start_weekday;
  logic [csbd_pkg::WD_W-1:0]   end_weekday;

  modport source (output valid, total_days, business_days, start_weekday,
                  end_weekday, input ready);
  modport sink (input valid, total_days, business_days, start_weekday,
                end_weekday, output ready);
endinterface

### sv/calendar_span_business_days.sv
// From request accept, the controller runs Q400, Q100, Q4, SUM, Q7 and WD for
// the start date, again for the end date, then INIT, WALK (one day per cycle in
// the datapath walk loop) and FIN. One request at a time; the next is taken
// once FIN returns to idle. The response register lets the next request start
// while a response waits. Reset (rst, synchronous) returns to idle, no response.
module calendar_span_business_days (
  input  logic       clk,
  input  logic       rst,
  csbd_req_if.sink   req,
  csbd_rsp_if.source rsp
);

  csbd_pkg::cmd_t  cmd;
  csbd_pkg::stat_t stat;

  csbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csbd_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .start_year   (req.start_year),
    .start_month  (req.start_month),
    .start_day    (req.start_day),
    .end_year     (req.end_year),
    .end_month    (req.end_month),
    .end_day      (req.end_day),
    .include_last (req.include_last),
    .rsp          (rsp)
  );

endmodule

### sv/csbd_ctrl.sv
module csbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  csbd_pkg::stat_t stat,
  output csbd_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_Q400 = 10'b00_0000_0010,
    ST_Q100 = 10'b00_0000_0100,
    ST_Q4   = 10'b00_0000_1000,
    ST_SUM  = 10'b00_0001_0000,
    ST_Q7   = 10'b00_0010_0000,
    ST_WD   = 10'b00_0100_0000,
    ST_INIT = 10'b00_1000_0000,
    ST_WALK = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   sel, sel_next;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_Q400;
          sel_next   = 1'b0;
        end
      end
      ST_Q400: state_next = ST_Q100;
      ST_Q100: state_next = ST_Q4;
      ST_Q4:   state_next = ST_SUM;
      ST_SUM:  state_next = ST_Q7;
      ST_Q7:   state_next = ST_WD;
      ST_WD: begin
        if (sel) begin
          state_next = ST_INIT;
        end else begin
          state_next = ST_Q400;
          sel_next   = 1'b1;
        end
      end
      ST_INIT: state_next = ST_WALK;
      ST_WALK: begin
        if (!stat.less) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.sel  = sel;
    cmd.load = (state == ST_IDLE) && req_valid;
    cmd.q400 = (state == ST_Q400);
    cmd.q100 = (state == ST_Q100);
    cmd.q4   = (state == ST_Q4);
    cmd.sum  = (state == ST_SUM);
    cmd.q7   = (state == ST_Q7);
    cmd.wd   = (state == ST_WD);
    cmd.init = (state == ST_INIT);
    cmd.walk = (state == ST_WALK);
    cmd.fin  = (state == ST_FIN) && !stat.out_busy;
  end

endmodule

### sv/csbd_dpath.sv
`include "calendar_span_business_days_macros.svh"

module csbd_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  csbd_pkg::cmd_t              cmd,
  output csbd_pkg::stat_t             stat,
  input  logic [csbd_pkg::YEAR_W-1:0] start_year,
  input  logic [csbd_pkg::MON_W-1:0]  start_month,
  input  logic [csbd_pkg::DAY_W-1:0]  start_day,
  input  logic [csbd_pkg::YEAR_W-1:0] end_year,
  input  logic [csbd_pkg::MON_W-1:0]  end_month,
  input  logic [csbd_pkg::DAY_W-1:0]  end_day,
  input  logic                        include_last,
  csbd_rsp_if.source                  rsp
);

  logic [csbd_pkg::YEAR_W-1:0] sy, ey, cy;
  logic [csbd_pkg::MON_W-1:0]  sm, em, cm;
  logic [csbd_pkg::DAY_W-1:0]  sd, ed, cd;
  logic                        inc;
  logic [csbd_pkg::R400_W-1:0] s400, c400;
  logic [4:0]                  q400, q4;
  logic [6:0]                  qh;
  logic [10:0]                 q7;
  logic [13:0]                 x;
  logic [csbd_pkg::WD_W-1:0]   sw, ew, cw;
  logic [csbd_pkg::CNT_W-1:0]  tot, biz;

  logic                        out_valid;
  logic [csbd_pkg::CNT_W-1:0]  out_tot, out_biz;
  logic [csbd_pkg::WD_W-1:0]   out_sw, out_ew;

  // selected date
  logic [csbd_pkg::YEAR_W-1:0] wy, wyy, wrem;
  logic [csbd_pkg::MON_W-1:0]  wm;
  logic [csbd_pkg::DAY_W-1:0]  wdr, wmlen, wdc;
  logic [csbd_pkg::R400_W-1:0] wr400;

  logic [csbd_pkg::MUL_A_W-1:0] mul_a;
  logic [csbd_pkg::MUL_K_W-1:0] mul_k;
  logic [csbd_pkg::PROD_W-1:0]  prod;

  logic [13:0]                 xsum, r7;
  logic [csbd_pkg::WD_W-1:0]   wdv;

  logic [csbd_pkg::DAY_W-1:0]  cmlen;
  logic                        less;

  function automatic logic [csbd_pkg::YEAR_W-1:0] clamp_year(
      input logic [csbd_pkg::YEAR_W-1:0] v);
    logic [csbd_pkg::YEAR_W-1:0] r;
    priority if (v < csbd_pkg::YEAR_MIN) r = csbd_pkg::YEAR_MIN;
    else if (v > csbd_pkg::YEAR_MAX)     r = csbd_pkg::YEAR_MAX;
    else                                 r = v;
    return r;
  endfunction

  function automatic logic [csbd_pkg::MON_W-1:0] clamp_month(
      input logic [csbd_pkg::MON_W-1:0] v);
    logic [csbd_pkg::MON_W-1:0] r;
    priority if (v < csbd_pkg::MON_MIN) r = csbd_pkg::MON_MIN;
    else if (v > csbd_pkg::MON_MAX)     r = csbd_pkg::MON_MAX;
    else                                r = v;
    return r;
  endfunction

  assign wy    = cmd.sel ? ey : sy;
  assign wm    = cmd.sel ? em : sm;
  assign wdr   = cmd.sel ? ed : sd;
  assign wyy   = wy - ((wm <= csbd_pkg::MON_FEB) ? 14'd1 : 14'd0);
  assign wrem  = wy - 14'(14'(q400) * 14'd400);
  assign wr400 = wrem[csbd_pkg::R400_W-1:0];
  assign wmlen = csbd_pkg::month_len(wm, csbd_pkg::is_leap400(wr400));

  always_comb begin
    priority if (wdr < csbd_pkg::DAY_MIN) wdc = csbd_pkg::DAY_MIN;
    else if (wdr > wmlen)                 wdc = wmlen;
    else                                  wdc = wdr;
  end

  // shared reciprocal multiplier
  always_comb begin
    mul_k = csbd_pkg::RECIP_100;
    priority if (cmd.q7) begin
      mul_a = x;
      mul_k = csbd_pkg::RECIP_7;
    end else if (cmd.q100) begin
      mul_a = wyy;
    end else if (cmd.q4) begin
      mul_a = {2'b00, wyy[13:2]};
    end else begin
      mul_a = {2'b00, wy[13:2]};
    end
  end

  assign prod = csbd_pkg::PROD_W'(mul_a) * csbd_pkg::PROD_W'(mul_k);

  assign xsum = 14'(wdr) + wyy + {2'b00, wyy[13:2]} - 14'(qh) + 14'(q4)
              + 14'(csbd_pkg::month_term(wm));
  assign r7   = x - 14'(14'(q7) * 14'd7);
  assign wdv  = (r7 >= 14'd7) ? 3'(r7 - 14'd7) : r7[2:0];

  assign cmlen = csbd_pkg::month_len(cm, csbd_pkg::is_leap400(c400));
  assign less  = (cy < ey) || ((cy == ey) && ((cm < em) || ((cm == em) && (cd < ed))));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sy  <= clamp_year(start_year);
      sm  <= clamp_month(start_month);
      sd  <= start_day;
      ey  <= clamp_year(end_year);
      em  <= clamp_month(end_month);
      ed  <= end_day;
      inc <= include_last;
    end
    if (cmd.q400) q400 <= prod[csbd_pkg::RECIP_100_SH+4:csbd_pkg::RECIP_100_SH];
    if (cmd.q100) begin
      qh <= prod[csbd_pkg::RECIP_100_SH+6:csbd_pkg::RECIP_100_SH];
      if (cmd.sel) begin
        ed <= wdc;
      end else begin
        sd   <= wdc;
        s400 <= wr400;
      end
    end
    if (cmd.q4)  q4 <= prod[csbd_pkg::RECIP_100_SH+4:csbd_pkg::RECIP_100_SH];
    if (cmd.sum) x  <= xsum;
    if (cmd.q7)  q7 <= prod[csbd_pkg::RECIP_7_SH+10:csbd_pkg::RECIP_7_SH];
    if (cmd.wd) begin
      if (cmd.sel) ew <= wdv;
      else         sw <= wdv;
    end
    if (cmd.init) begin
      cy   <= sy;
      cm   <= sm;
      cd   <= sd;
      c400 <= s400;
      cw   <= sw;
      tot  <= '0;
      biz  <= '0;
    end else if (cmd.walk && less) begin
      tot <= tot + 22'd1;
      if ((cw != csbd_pkg::WD_SUNDAY) && (cw != csbd_pkg::WD_SATURDAY)) begin
        biz <= biz + 22'd1;
      end
      cw <= (cw == csbd_pkg::WD_SATURDAY) ? csbd_pkg::WD_SUNDAY : cw + 3'd1;
      if (cd == cmlen) begin
        cd <= csbd_pkg::DAY_MIN;
        if (cm == csbd_pkg::MON_MAX) begin
          cm   <= csbd_pkg::MON_MIN;
          cy   <= cy + 14'd1;
          c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
        end else begin
          cm <= cm + 4'd1;
        end
      end else begin
        cd <= cd + 5'd1;
      end
    end
    if (cmd.fin) begin
      out_tot <= tot + 22'(inc);
      out_biz <= biz;
      out_sw  <= sw;
      out_ew  <= ew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.less     = less;
  assign stat.out_busy = out_valid && !rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.total_days    = out_tot;
  assign rsp.business_days = out_biz;
  assign rsp.start_weekday = out_sw;
  assign rsp.end_weekday   = out_ew;

  `CSBD_ASSERT_NEXT(a_walk_count, cmd.walk && less, tot == $past(tot) + 22'd1, "span count did not step")
  `CSBD_ASSERT_NOW(a_biz_le_tot, cmd.walk, biz <= tot, "business count exceeds span")
  `CSBD_ASSERT_NEXT(a_start_wd, cmd.wd && !cmd.sel, sw <= csbd_pkg::WD_SATURDAY, "start weekday out of range")
  `CSBD_ASSERT_NEXT(a_end_wd, cmd.wd && cmd.sel, ew <= csbd_pkg::WD_SATURDAY, "end weekday out of range")

endmodule
